[src/qrbg_pkg.sv]
// ----------------------------------------------------------------------------
// qrbg_pkg
// Shared types and constants of the quadratic residue bit generator.
// ----------------------------------------------------------------------------
package qrbg_pkg;

  localparam int unsigned SEED_WIDTH = 32;
  localparam int unsigned PRIME_WIDTH = 16;
  localparam int unsigned LEN_WIDTH = 7;
  localparam int unsigned CFG_IDX_WIDTH = 2;
  localparam int unsigned MM_CNT_WIDTH = $clog2(SEED_WIDTH + 1);

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_PRIME_FIRST = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_PRIME_SECOND = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SEED_VALUE = 2'd2;

  localparam logic [PRIME_WIDTH-1:0] PRIME_FIRST_RST = 16'd383;
  localparam logic [PRIME_WIDTH-1:0] PRIME_SECOND_RST = 16'd503;
  localparam logic [SEED_WIDTH-1:0] SEED_VALUE_RST = 32'd101355;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_PRIME,
    ST_RUN
  } qrbg_state_t;

endpackage

[src/qrbg_modmul.sv]
// ----------------------------------------------------------------------------
// qrbg_modmul
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle,
// MSB first, acc = (2*acc + bit*b) mod n with b below n.
// ----------------------------------------------------------------------------
module qrbg_modmul #(
  parameter int unsigned STATE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  logic [qrbg_pkg::SEED_WIDTH-1:0] mul_a,
  input  logic [STATE_WIDTH-1:0]          mul_b,
  input  logic [STATE_WIDTH-1:0]          modulus,
  output logic                            done,
  output logic [STATE_WIDTH-1:0]          result
);
  import qrbg_pkg::*;

  localparam int unsigned TW = STATE_WIDTH + 3;

  logic [SEED_WIDTH-1:0]   a_sr_r;
  logic [STATE_WIDTH-1:0]  b_r;
  logic [STATE_WIDTH-1:0]  n_r;
  logic [STATE_WIDTH-1:0]  acc_r;
  logic [STATE_WIDTH-1:0]  acc_nxt;
  logic [MM_CNT_WIDTH-1:0] cnt_r;
  logic                    busy_r;
  logic                    done_r;
  logic [TW-1:0]           t;
  logic [TW-1:0]           d1;
  logic [TW-1:0]           d2;

  always_comb begin
    t  = {2'b00, acc_r, 1'b0} + (a_sr_r[SEED_WIDTH-1] ? {3'b000, b_r} : '0);
    d1 = t - {3'b000, n_r};
    d2 = t - {2'b00, n_r, 1'b0};
    if (!d2[TW-1]) begin
      acc_nxt = d2[STATE_WIDTH-1:0];
    end else if (!d1[TW-1]) begin
      acc_nxt = d1[STATE_WIDTH-1:0];
    end else begin
      acc_nxt = t[STATE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == MM_CNT_WIDTH'(1));
      if (load) begin
        busy_r <= 1'b1;
        cnt_r  <= MM_CNT_WIDTH'(SEED_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - MM_CNT_WIDTH'(1);
        if (cnt_r == MM_CNT_WIDTH'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_sr_r <= mul_a;
      b_r    <= mul_b;
      n_r    <= modulus;
      acc_r  <= '0;
    end else if (busy_r) begin
      a_sr_r <= {a_sr_r[SEED_WIDTH-2:0], 1'b0};
      acc_r  <= acc_nxt;
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

[src/quadratic_residue_bit_generator_unit.sv]
// ----------------------------------------------------------------------------
// quadratic_residue_bit_generator_unit
// Blum Blum Shub generator: n = p*q, x0 = seed^2 mod n, then one squaring
// mod n per output bit.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+-------------------------
//   request | in_run_length                           | start high, busy low
//   result  | out_bit_out, out_state_value, out_last  | out_valid, one cycle
//   config  | cfg_index, cfg_wdata                    | cfg_we, no wait
//
// Each modular step runs in the bit-serial multiplier and is then handed
// over to the next: seed reduction, squaring to x0, then one squaring per
// bit. A run length of zero is taken and produces nothing. Reset restores
// the configuration defaults. The receiver cannot stall.
// ----------------------------------------------------------------------------
module quadratic_residue_bit_generator_unit #(
  parameter int unsigned STATE_WIDTH = 32,
  parameter int unsigned MAX_RUN = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [qrbg_pkg::LEN_WIDTH-1:0]     in_run_length,
  output logic                               out_valid,
  output logic                               out_bit_out,
  output logic [STATE_WIDTH-1:0]             out_state_value,
  output logic                               out_last,
  input  logic                               cfg_we,
  input  logic [qrbg_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [qrbg_pkg::SEED_WIDTH-1:0]    cfg_wdata
);
  import qrbg_pkg::*;

  logic [PRIME_WIDTH-1:0]   prime_first_r;
  logic [PRIME_WIDTH-1:0]   prime_second_r;
  logic [SEED_WIDTH-1:0]    seed_value_r;
  qrbg_state_t              state_r;
  qrbg_state_t              state_nxt;
  logic [LEN_WIDTH-1:0]     left_r;
  logic [LEN_WIDTH-1:0]     left_nxt;
  logic [STATE_WIDTH-1:0]   n_r;
  logic                     nzero_r;
  logic [2*PRIME_WIDTH-1:0] prod;
  logic [STATE_WIDTH-1:0]   n_now;
  logic [LEN_WIDTH-1:0]     len_sat;
  logic                     accept;
  logic                     mm_load;
  logic [SEED_WIDTH-1:0]    mm_a;
  logic [STATE_WIDTH-1:0]   mm_b;
  logic [STATE_WIDTH-1:0]   mm_mod;
  logic                     mm_done;
  logic [STATE_WIDTH-1:0]   mm_result;
  logic [STATE_WIDTH-1:0]   xv;
  logic                     emit;
  logic                     out_valid_r;
  logic                     out_bit_out_r;
  logic [STATE_WIDTH-1:0]   out_state_value_r;
  logic                     out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_first_r  <= PRIME_FIRST_RST;
      prime_second_r <= PRIME_SECOND_RST;
      seed_value_r   <= SEED_VALUE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRIME_FIRST:  prime_first_r  <= cfg_wdata[PRIME_WIDTH-1:0];
        CFG_PRIME_SECOND: prime_second_r <= cfg_wdata[PRIME_WIDTH-1:0];
        CFG_SEED_VALUE:   seed_value_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign prod   = prime_first_r * prime_second_r;
  assign n_now  = prod[STATE_WIDTH-1:0];
  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign len_sat = (in_run_length > LEN_WIDTH'(MAX_RUN)) ? LEN_WIDTH'(MAX_RUN)
                                                         : in_run_length;
  assign xv     = nzero_r ? '0 : mm_result;

  always_comb begin
    state_nxt = state_r;
    left_nxt  = left_r;
    mm_load   = 1'b0;
    mm_a      = SEED_WIDTH'(xv);
    mm_b      = xv;
    mm_mod    = n_r;
    emit      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        mm_a   = seed_value_r;
        mm_b   = STATE_WIDTH'(1);
        mm_mod = n_now;
        if (accept && (in_run_length != '0)) begin
          mm_load   = 1'b1;
          left_nxt  = len_sat;
          state_nxt = ST_SEED;
        end
      end
      ST_SEED: begin
        if (mm_done) begin
          mm_load   = 1'b1;
          state_nxt = ST_PRIME;
        end
      end
      ST_PRIME: begin
        if (mm_done) begin
          mm_load   = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (mm_done) begin
          emit     = 1'b1;
          left_nxt = left_r - LEN_WIDTH'(1);
          if (left_r == LEN_WIDTH'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            mm_load = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      left_r      <= left_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      n_r     <= n_now;
      nzero_r <= (n_now == '0);
    end
    if (emit) begin
      out_bit_out_r     <= xv[0];
      out_state_value_r <= xv;
      out_last_r        <= (left_r == LEN_WIDTH'(1));
    end
  end

  qrbg_modmul #(
    .STATE_WIDTH(STATE_WIDTH)
  ) u_modmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (mm_load),
    .mul_a   (mm_a),
    .mul_b   (mm_b),
    .modulus (mm_mod),
    .done    (mm_done),
    .result  (mm_result)
  );

  assign out_valid       = out_valid_r;
  assign out_bit_out     = out_bit_out_r;
  assign out_state_value = out_state_value_r;
  assign out_last        = out_last_r;

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the quadratic residue bit generator. Requests of
// directed and random run lengths are sent under several modulus and seed
// settings. A scoreboard predicts each generated bit and squared value and
// compares the result stream field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
  import qrbg_pkg::*;

  localparam int unsigned MAX_BITS = 64;
  localparam int unsigned STALL_LIMIT = 6000;
  localparam int unsigned SETTLE_CYCLES = 150;
  localparam int unsigned RANDOM_PER_PHASE = 30;
  localparam int unsigned NUM_PHASES = 9;

  typedef struct packed {
    logic        bit_out;
    logic [31:0] state_value;
    logic        last;
  } qrbg_bit_t;

  class qrbg_scoreboard;
    logic [PRIME_WIDTH-1:0] prime_first;
    logic [PRIME_WIDTH-1:0] prime_second;
    logic [SEED_WIDTH-1:0]  seed_value;
    qrbg_bit_t              pending_bits[$];
    int unsigned            fail_count;

    function new();
      prime_first = PRIME_FIRST_RST;
      prime_second = PRIME_SECOND_RST;
      seed_value = SEED_VALUE_RST;
      fail_count = 0;
    endfunction

    function void write_register(logic [CFG_IDX_WIDTH-1:0] idx, logic [SEED_WIDTH-1:0] data);
      case (idx)
        CFG_PRIME_FIRST: prime_first = data[PRIME_WIDTH-1:0];
        CFG_PRIME_SECOND: prime_second = data[PRIME_WIDTH-1:0];
        CFG_SEED_VALUE: seed_value = data;
        default: ;
      endcase
    endfunction

    function logic [31:0] square_reduce(logic [31:0] v, logic [31:0] n);
      logic [63:0] r;
      if (n == 32'd0) return 32'd0;
      r = {32'd0, v} % {32'd0, n};
      r = (r * r) % {32'd0, n};
      return r[31:0];
    endfunction

    function void take_run_request(logic [LEN_WIDTH-1:0] len);
      logic [31:0] modulus;
      logic [31:0] x;
      int unsigned count;
      qrbg_bit_t   item;
      modulus = {16'd0, prime_first} * {16'd0, prime_second};
      count = (len > MAX_BITS) ? MAX_BITS : len;
      x = square_reduce(seed_value, modulus);
      for (int unsigned k = 0; k < count; k++) begin
        x = square_reduce(x, modulus);
        item.bit_out = x[0];
        item.state_value = x;
        item.last = (k + 1 == count);
        pending_bits.push_back(item);
      end
    endfunction

    function void check_bit(logic b, logic [31:0] v, logic l);
      qrbg_bit_t want;
      if (pending_bits.size() == 0) begin
        $display("%0t: unexpected result bit_out=%0b state_value=%0h last=%0b",
                 $time, b, v, l);
        fail_count++;
        return;
      end
      want = pending_bits.pop_front();
      if (b !== want.bit_out) begin
        $display("%0t: bit_out mismatch expected %0b actual %0b", $time, want.bit_out, b);
        fail_count++;
      end
      if (v !== want.state_value) begin
        $display("%0t: state_value mismatch expected %0h actual %0h",
                 $time, want.state_value, v);
        fail_count++;
      end
      if (l !== want.last) begin
        $display("%0t: last mismatch expected %0b actual %0b", $time, want.last, l);
        fail_count++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [LEN_WIDTH-1:0]     in_run_length;
  logic                     out_valid;
  logic                     out_bit_out;
  logic [31:0]              out_state_value;
  logic                     out_last;
  logic                     cfg_we;
  logic [CFG_IDX_WIDTH-1:0] cfg_index;
  logic [SEED_WIDTH-1:0]    cfg_wdata;

  qrbg_scoreboard sb;
  int unsigned    idle_pct;
  int unsigned    quiet_cycles = 0;

  quadratic_residue_bit_generator_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_run_length(in_run_length),
    .out_valid(out_valid),
    .out_bit_out(out_bit_out),
    .out_state_value(out_state_value),
    .out_last(out_last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_bit(out_bit_out, out_state_value, out_last);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no activity", $time);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [SEED_WIDTH-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.write_register(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_config(input logic [PRIME_WIDTH-1:0] p,
                             input logic [PRIME_WIDTH-1:0] q,
                             input logic [SEED_WIDTH-1:0] seed);
    write_reg(CFG_PRIME_FIRST, {16'd0, p});
    write_reg(CFG_PRIME_SECOND, {16'd0, q});
    write_reg(CFG_SEED_VALUE, seed);
  endtask

  // start stays high from one request to the next unless the sender idles
  task automatic send_run(input logic [LEN_WIDTH-1:0] len);
    @(negedge clk);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_run_length <= len;
    do @(posedge clk); while (busy !== 1'b0);
    sb.take_run_request(len);
  endtask

  task automatic wait_drain();
    while (sb.pending_bits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [LEN_WIDTH-1:0] pick_run_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 60) return LEN_WIDTH'($urandom_range(1, 8));
    if (r < 90) return LEN_WIDTH'($urandom_range(9, 64));
    return LEN_WIDTH'($urandom_range(65, 127));
  endfunction

  initial begin
    int directed[$];
    rst_n = 1'b0;
    start = 1'b0;
    in_run_length = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    idle_pct = 0;
    sb = new();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      idle_pct = (ph < 3) ? 22 : (ph < 6) ? 61 : 0;
      directed.delete();
      case (ph)
        0: directed = '{1, 64, 65, 127, 0, 2, 63};
        1: begin
          // zero modulus
          load_config(16'd0, 16'd503, 32'd101355);
          directed = '{5, 0, 64};
        end
        2: begin
          // modulus of one
          load_config(16'd1, 16'd1, 32'd12345);
          directed = '{4};
        end
        3: begin
          load_config(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
          directed = '{64, 1};
        end
        4: begin
          load_config(16'd7, 16'd11, 32'd0);
          directed = '{12};
        end
        5: load_config(16'd65519, 16'd65503, 32'd1);
        6: load_config(16'd3, 16'd3, 32'd2);
        default: load_config(PRIME_WIDTH'($urandom_range(3, 65535)),
                             PRIME_WIDTH'($urandom_range(3, 65535)), $urandom());
      endcase
      foreach (directed[i]) send_run(LEN_WIDTH'(directed[i]));
      repeat (RANDOM_PER_PHASE) send_run(pick_run_length());
      @(negedge clk);
      start <= 1'b0;
      wait_drain();
    end

    if (sb.fail_count == 0 && sb.pending_bits.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
